@@ src/lwkd_pkg.sv @@
// Shared widths, constants and item type for the longest-window block.
`default_nettype none
package lwkd_pkg;

    localparam int SYM_W     = 8;
    localparam int DIST_W    = 9;
    localparam int BEST_W    = 13;

    localparam logic [DIST_W-1:0] MAX_DISTINCT_RESET = 9'd2;

    // one queued byte after symbol reduction
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
    } t_item;

endpackage
`default_nettype wire

@@ src/lwkd_if.sv @@
// Channel interfaces: input bytes, results and the limit register write.
`default_nettype none
interface lwkd_in_if;
    logic                      valid;
    logic                      ready;
    logic [lwkd_pkg::SYM_W-1:0] char_in;
    logic                      end_of_string;

    modport source (output valid, output char_in, output end_of_string, input ready);
    modport sink   (input valid, input char_in, input end_of_string, output ready);
endinterface

interface lwkd_out_if;
    logic                       valid;
    logic                       ready;
    logic [lwkd_pkg::BEST_W-1:0] best_length;
    logic                       is_final;
    logic                       overflow;

    modport source (output valid, output best_length, output is_final, output overflow,
                    input ready);
    modport sink   (input valid, input best_length, input is_final, input overflow,
                    output ready);
endinterface

interface lwkd_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lwkd_pkg::DIST_W-1:0] max_distinct;

    modport source (output valid, output max_distinct, input ready);
    modport sink   (input valid, input max_distinct, output ready);
endinterface
`default_nettype wire

@@ src/lwkd_front.sv @@
// Front end: accepts bytes, folds them into the alphabet and pushes them on the queue.
`default_nettype none
module lwkd_front #(
    parameter int ALPHABET_SIZE = 256
) (
    lwkd_in_if.sink         i_in,
    input  wire logic       i_full,
    output lwkd_pkg::t_item o_push_item,
    output logic            o_push_valid
);
    import lwkd_pkg::*;

    localparam int BYTE_VALUES = 1 << SYM_W;

    typedef logic [BYTE_VALUES-1:0][SYM_W-1:0] t_fold_table;

    // byte value to symbol, worked out at elaboration
    function automatic t_fold_table f_fold_table();
        t_fold_table t;
        for (int v = 0; v < BYTE_VALUES; v++) begin
            t[v] = SYM_W'(v % ALPHABET_SIZE);
        end
        return t;
    endfunction

    localparam t_fold_table FOLD = f_fold_table();

    assign i_in.ready       = !i_full;
    assign o_push_valid     = i_in.valid;
    assign o_push_item.sym  = FOLD[i_in.char_in];
    assign o_push_item.last = i_in.end_of_string;

endmodule
`default_nettype wire

@@ src/lwkd_queue.sv @@
// Two-entry queue between the front end and the window engine.
`default_nettype none
module lwkd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire lwkd_pkg::t_item i_push_item,
    input  wire logic            i_pop,
    output lwkd_pkg::t_item      o_pop_item,
    output logic                 o_full,
    output logic                 o_empty
);
    import lwkd_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full     = (r_count == 2'd2);
    assign o_empty    = (r_count == 2'd0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_pop_item = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ src/lwkd_back.sv @@
// Window engine: ring of bytes, per-symbol counts, distinct count and result register.
`default_nettype none
module lwkd_back #(
    parameter int WINDOW_DEPTH  = 4096,
    parameter int ALPHABET_SIZE = 256
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire lwkd_pkg::t_item i_item,
    input  wire logic            i_empty,
    output logic                 o_pop,
    lwkd_cfg_if.sink             i_cfg,
    lwkd_out_if.source           o_out
);
    import lwkd_pkg::*;

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int LW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_DROP_RD, S_DROP_CNT, S_DROP_WR, S_ADD_RD, S_ADD_WR, S_CHECK, S_OUT
    } t_state;

    t_state            r_state;
    logic [DIST_W-1:0] r_max_distinct;
    logic [DIST_W-1:0] r_distinct;
    logic [AW-1:0]     r_tail;
    logic [AW-1:0]     r_head;
    logic [LW-1:0]     r_len;
    logic [LW-1:0]     r_best;
    logic              r_ovf;
    logic              r_then_add;
    logic [SYM_W-1:0]  r_sym;
    logic              r_last;
    logic [SYM_W-1:0]  r_drop_sym;
    logic              r_out_valid;
    logic [BEST_W-1:0] r_out_best;
    logic              r_out_final;
    logic              r_out_ovf;

    // memories and their registered read data
    logic [SYM_W-1:0]  r_ring [WINDOW_DEPTH];
    logic [SYM_W-1:0]  r_ring_q;
    logic [LW-1:0]     r_cnt [ALPHABET_SIZE];
    logic [LW-1:0]     r_cnt_q;
    logic              r_cnt_vld [ALPHABET_SIZE];
    logic              r_cnt_q_vld;

    logic              out_free;
    logic              ring_we;
    logic              ring_re;
    logic              cnt_re;
    logic              cnt_we;
    logic [SW-1:0]     cnt_rd_addr;
    logic [SW-1:0]     cnt_wr_addr;
    logic [LW-1:0]     cnt_wr_data;
    logic [LW-1:0]     cnt_cur;
    logic              clear_str;

    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = r_out_valid;
    assign o_out.best_length = r_out_best;
    assign o_out.is_final    = r_out_final;
    assign o_out.overflow    = r_out_ovf;

    assign out_free  = !r_out_valid || o_out.ready;
    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign cnt_cur   = r_cnt_q_vld ? r_cnt_q : '0;
    assign ring_re   = (r_state == S_DROP_RD);
    assign ring_we   = (r_state == S_ADD_WR);
    assign clear_str = (r_state == S_OUT) && out_free && r_last;

    always_comb begin
        cnt_re      = 1'b0;
        cnt_rd_addr = r_sym[SW-1:0];
        cnt_we      = 1'b0;
        cnt_wr_addr = r_sym[SW-1:0];
        cnt_wr_data = cnt_cur + LW'(1);
        unique case (r_state)
            S_DROP_CNT: begin
                cnt_re      = 1'b1;
                cnt_rd_addr = r_ring_q[SW-1:0];
            end
            S_ADD_RD: begin
                cnt_re = 1'b1;
            end
            S_DROP_WR: begin
                cnt_we      = (cnt_cur != '0);
                cnt_wr_addr = r_drop_sym[SW-1:0];
                cnt_wr_data = cnt_cur - LW'(1);
            end
            S_ADD_WR: begin
                cnt_we = 1'b1;
            end
            default: begin
                cnt_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_head] <= r_sym;
        end
        if (ring_re) begin
            r_ring_q <= r_ring[r_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt[cnt_wr_addr] <= cnt_wr_data;
        end
        if (cnt_re) begin
            r_cnt_q     <= r_cnt[cnt_rd_addr];
            r_cnt_q_vld <= r_cnt_vld[cnt_rd_addr];
        end
    end

    // an entry without its valid bit reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear_str) begin
            for (int i = 0; i < ALPHABET_SIZE; i++) begin
                r_cnt_vld[i] <= 1'b0;
            end
        end else if (cnt_we) begin
            r_cnt_vld[cnt_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_distinct <= MAX_DISTINCT_RESET;
        end else if (i_cfg.valid) begin
            r_max_distinct <= i_cfg.max_distinct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_distinct  <= '0;
            r_tail      <= '0;
            r_head      <= '0;
            r_len       <= '0;
            r_best      <= '0;
            r_ovf       <= 1'b0;
            r_then_add  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_sym  <= i_item.sym;
                        r_last <= i_item.last;
                        // window full: push the oldest byte out first
                        if (r_len == LW'(WINDOW_DEPTH)) begin
                            r_ovf      <= 1'b1;
                            r_then_add <= 1'b1;
                            r_state    <= S_DROP_RD;
                        end else begin
                            r_state <= S_ADD_RD;
                        end
                    end
                end
                S_DROP_RD: begin
                    r_state <= S_DROP_CNT;
                end
                S_DROP_CNT: begin
                    r_drop_sym <= r_ring_q;
                    r_state    <= S_DROP_WR;
                end
                S_DROP_WR: begin
                    if (cnt_cur == LW'(1) && r_distinct != '0) begin
                        r_distinct <= r_distinct - DIST_W'(1);
                    end
                    r_tail     <= (r_tail == AW'(WINDOW_DEPTH - 1)) ? '0 : r_tail + AW'(1);
                    r_len      <= r_len - LW'(1);
                    r_then_add <= 1'b0;
                    r_state    <= r_then_add ? S_ADD_RD : S_CHECK;
                end
                S_ADD_RD: begin
                    r_state <= S_ADD_WR;
                end
                S_ADD_WR: begin
                    if (cnt_cur == '0) begin
                        r_distinct <= r_distinct + DIST_W'(1);
                    end
                    r_head  <= (r_head == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head + AW'(1);
                    r_len   <= r_len + LW'(1);
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_len != '0 && r_distinct > r_max_distinct) begin
                        r_state <= S_DROP_RD;
                    end else begin
                        if (r_len > r_best) begin
                            r_best <= r_len;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_best  <= BEST_W'(r_best);
                        r_out_final <= r_last;
                        r_out_ovf   <= r_ovf;
                        if (r_last) begin
                            r_distinct <= '0;
                            r_tail     <= '0;
                            r_head     <= '0;
                            r_len      <= '0;
                            r_best     <= '0;
                            r_ovf      <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ src/longest_window_k_distinct.sv @@
// Top level of the longest window with at most k distinct byte values.
// Bytes arrive one per word on i_in and every byte yields one result word on o_out: the
// longest window so far in the current string holding at most max_distinct distinct
// values, whether it is the string's last byte, and whether a window ever ran past
// WINDOW_DEPTH (the length then saturates there). The byte flagged end_of_string clears
// all string state once its result is issued. Bytes are folded modulo ALPHABET_SIZE.
// A two-word queue decouples the input from the window engine. The engine handles one
// byte at a time: a count read, a count and ring write, a limit check and the result
// output per byte, plus a ring read, a count read, a count write and a fresh limit check
// for each old byte dropped to get back under the limit, and the first three of those
// when a full ring pushes its oldest byte out, all through single-port, registered-read
// memories. Every byte is dropped at most once; a held-off result output stalls the engine.
// max_distinct resets to 2; the user must write it on i_cfg while idle (no check in the block).
`default_nettype none
module longest_window_k_distinct #(
    parameter int WINDOW_DEPTH  = 4096,
    parameter int ALPHABET_SIZE = 256
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lwkd_in_if.sink    i_in,
    lwkd_cfg_if.sink   i_cfg,
    lwkd_out_if.source o_out
);
    import lwkd_pkg::*;

    t_item push_item;
    t_item pop_item;
    logic  push_valid;
    logic  q_full;
    logic  q_empty;
    logic  pop;

    lwkd_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .i_in         (i_in),
        .i_full       (q_full),
        .o_push_item  (push_item),
        .o_push_valid (push_valid)
    );

    lwkd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push_valid),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_pop_item  (pop_item),
        .o_full      (q_full),
        .o_empty     (q_empty)
    );

    lwkd_back #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (pop_item),
        .i_empty (q_empty),
        .o_pop   (pop),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

@@ bench/longest_window_k_distinct_tb.sv @@
// Self-checking bench for the longest window with at most k distinct byte values.
`timescale 1ns / 100ps
module longest_window_k_distinct_tb;
    import lwkd_pkg::*;

    localparam int WINDOW_DEPTH  = 4096;
    localparam int ALPHABET_SIZE = 256;
    localparam int IDLE_LIMIT    = 100000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PER_LIMIT = 115;

    typedef struct packed {
        logic [BEST_W-1:0] best_length;
        logic              is_final;
        logic              overflow;
    } t_answer;

    typedef logic [SYM_W-1:0] t_bytes[$];

    logic i_clk = 1'b0;
    logic i_rst_n;

    lwkd_in_if  in_bus();
    lwkd_cfg_if cfg_bus();
    lwkd_out_if res_bus();

    longest_window_k_distinct #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .i_cfg  (cfg_bus),
        .o_out  (res_bus)
    );

    always #1 i_clk = ~i_clk;

    // window state mirrored from the block
    int               sym_count [ALPHABET_SIZE];
    int               distinct_now;
    logic [SYM_W-1:0] win_ring  [WINDOW_DEPTH];
    int               win_tail;
    int               win_len;
    int               best_len;
    logic             ovf_seen;
    logic [DIST_W-1:0] max_distinct;

    t_answer answers_due[$];
    int      errors = 0;

    // sender and receiver pacing
    int  burst_left = 0;
    bit  gaps_on = 1'b1;
    int  hold_requests = 0;

    function automatic void clear_string();
        for (int i = 0; i < ALPHABET_SIZE; i++) sym_count[i] = 0;
        distinct_now = 0;
        win_tail     = 0;
        win_len      = 0;
        best_len     = 0;
        ovf_seen     = 1'b0;
    endfunction

    function automatic void evict_oldest();
        int s;
        if (win_len == 0) return;
        s = int'(win_ring[win_tail]) % ALPHABET_SIZE;
        if (sym_count[s] > 0) begin
            sym_count[s]--;
            if (sym_count[s] == 0 && distinct_now > 0) distinct_now--;
        end
        win_tail = (win_tail == WINDOW_DEPTH - 1) ? 0 : win_tail + 1;
        win_len--;
    endfunction

    function automatic t_answer slide_window(logic [SYM_W-1:0] ch, logic last);
        int      s;
        int      head;
        t_answer a;
        s = int'(ch) % ALPHABET_SIZE;
        // full ring: oldest byte is pushed out regardless of the limit
        if (win_len >= WINDOW_DEPTH) begin
            ovf_seen = 1'b1;
            evict_oldest();
        end
        head = win_tail + win_len;
        if (head >= WINDOW_DEPTH) head -= WINDOW_DEPTH;
        win_ring[head] = s[SYM_W-1:0];
        win_len++;
        if (sym_count[s] == 0) distinct_now++;
        sym_count[s]++;
        while (win_len > 0 && distinct_now > int'(max_distinct)) evict_oldest();
        if (win_len > best_len) best_len = win_len;
        a.best_length = best_len[BEST_W-1:0];
        a.is_final    = last;
        a.overflow    = ovf_seen;
        if (last) clear_string();
        return a;
    endfunction

    // one byte word; valid stays high into the next word unless a gap falls here
    task automatic send_byte(input logic [SYM_W-1:0] ch, input logic last);
        in_bus.valid         <= 1'b1;
        in_bus.char_in       <= ch;
        in_bus.end_of_string <= last;
        do @(posedge i_clk); while (!in_bus.ready);
        answers_due.push_back(slide_window(ch, last));
        if (burst_left > 0) begin
            burst_left--;
        end else if (gaps_on) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 4);
        end
    endtask

    task automatic send_string(input t_bytes s);
        foreach (s[i]) send_byte(s[i], i == s.size() - 1);
    endtask

    task automatic wait_all_answered();
        in_bus.valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [DIST_W-1:0] lim);
        wait_all_answered();
        cfg_bus.valid        <= 1'b1;
        cfg_bus.max_distinct <= lim;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        max_distinct = lim;
    endtask

    task automatic test_directed();
        // reset value of the limit is relied on for the first strings
        send_string('{8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA});
        send_string('{8'h80});
        write_limit(9'd0);
        send_string('{8'h12, 8'h34});
        write_limit(9'd1);
        send_string('{8'h7F, 8'h7F, 8'h01, 8'h01});
        write_limit(9'd256);
        send_string('{8'h00, 8'h11, 8'h22, 8'h33, 8'hFF});
        write_limit(9'd255);
        send_string('{8'h01, 8'h02});
        wait_all_answered();
    endtask

    // two values under a limit of two never shrink the window, so the ring fills
    task automatic test_window_full();
        write_limit(9'd2);
        for (int i = 0; i < WINDOW_DEPTH + 4; i++)
            send_byte($urandom_range(0, 1) ? 8'h01 : 8'h00, 1'b0);
        // third value forces a long run of drops
        send_byte(8'h02, 1'b0);
        send_byte(8'h02, 1'b1);
        wait_all_answered();
    endtask

    task automatic test_output_backpressure();
        write_limit(9'd3);
        gaps_on = 1'b0;
        hold_requests++;
        for (int i = 0; i < 40; i++)
            send_byte(SYM_W'($urandom_range(0, 4)), i == 39);
        gaps_on = 1'b1;
        wait_all_answered();
    endtask

    task automatic test_random_strings();
        logic [DIST_W-1:0] limits [10];
        logic [SYM_W-1:0]  pool [ALPHABET_SIZE];
        t_bytes            s;
        int                sent;
        int                len;
        int                pool_n;
        limits = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd4, 9'd7, 9'd16, 9'd255, 9'd256, 9'd0};
        limits[9] = DIST_W'($urandom_range(5, 40));
        foreach (limits[k]) begin
            write_limit(limits[k]);
            sent = 0;
            while (sent < RANDOM_PER_LIMIT) begin
                len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24)
                                                   : $urandom_range(25, 260);
                if (limits[k] >= 9'd32)
                    pool_n = $urandom_range(1, ALPHABET_SIZE);
                else
                    pool_n = $urandom_range(1, int'(limits[k]) + 3);
                for (int i = 0; i < pool_n; i++) pool[i] = SYM_W'($urandom_range(0, 255));
                s.delete();
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        s.push_back(SYM_W'($urandom_range(0, 255)));
                    else
                        s.push_back(pool[$urandom_range(0, pool_n - 1)]);
                end
                send_string(s);
                sent += len;
            end
        end
        wait_all_answered();
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        t_answer want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (answers_due.size() == 0) begin
                $error("unexpected result word: best_length %0d", res_bus.best_length);
                errors++;
            end else begin
                want = answers_due.pop_front();
                if (res_bus.best_length !== want.best_length) begin
                    $error("best_length: expected %0d, got %0d",
                           want.best_length, res_bus.best_length);
                    errors++;
                end
                if (res_bus.is_final !== want.is_final) begin
                    $error("is_final: expected %0d, got %0d", want.is_final, res_bus.is_final);
                    errors++;
                end
                if (res_bus.overflow !== want.overflow) begin
                    $error("overflow: expected %0d, got %0d", want.overflow, res_bus.overflow);
                    errors++;
                end
            end
        end
    end

    // receiver: stall rate changes now and then; a hold request blocks it for a long stretch
    initial begin : drive_ready
        int stall_pct;
        int phase_left;
        int hold_left;
        int holds_done;
        stall_pct     = 0;
        phase_left    = 0;
        hold_left     = 0;
        holds_done    = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (phase_left == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    2: stall_pct = 50;
                    default: stall_pct = 80;
                endcase
                phase_left = $urandom_range(16, 200);
            end else begin
                phase_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_bus.valid && in_bus.ready) || (res_bus.valid && res_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n              = 1'b0;
        in_bus.valid         = 1'b0;
        in_bus.char_in       = '0;
        in_bus.end_of_string = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.max_distinct = '0;
        max_distinct         = MAX_DISTINCT_RESET;
        clear_string();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_window_full();
        test_output_backpressure();
        test_random_strings();

        wait_all_answered();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
src/lwkd_pkg.sv
src/lwkd_if.sv
src/lwkd_front.sv
src/lwkd_queue.sv
src/lwkd_back.sv
src/longest_window_k_distinct.sv
bench/longest_window_k_distinct_tb.sv
